>>> rtl/mfp_pkg.sv
`default_nettype none
package mfp_pkg;

   localparam logic [2:0] KIND_READ  = 3'd0;
   localparam logic [2:0] KIND_WRITE = 3'd1;
   localparam logic [2:0] KIND_PIN   = 3'd2;
   localparam logic [2:0] KIND_TICK  = 3'd3;
   localparam logic [2:0] KIND_ACK   = 3'd4;

   localparam logic [4:0] REG_GPIO    = 5'h00;
   localparam logic [4:0] REG_EDGE    = 5'h01;
   localparam logic [4:0] REG_DDR     = 5'h02;
   localparam logic [4:0] REG_IERA    = 5'h03;
   localparam logic [4:0] REG_IERB    = 5'h04;
   localparam logic [4:0] REG_IPRA    = 5'h05;
   localparam logic [4:0] REG_IPRB    = 5'h06;
   localparam logic [4:0] REG_ISRA    = 5'h07;
   localparam logic [4:0] REG_ISRB    = 5'h08;
   localparam logic [4:0] REG_IMRA    = 5'h09;
   localparam logic [4:0] REG_IMRB    = 5'h0a;
   localparam logic [4:0] REG_VR      = 5'h0b;
   localparam logic [4:0] REG_TACR    = 5'h0c;
   localparam logic [4:0] REG_TBCR    = 5'h0d;
   localparam logic [4:0] REG_TCDCR   = 5'h0e;
   localparam logic [4:0] REG_TADR    = 5'h0f;
   localparam logic [4:0] REG_TBDR    = 5'h10;
   localparam logic [4:0] REG_TCDR    = 5'h11;
   localparam logic [4:0] REG_TDDR    = 5'h12;

   localparam logic [7:0] SPURIOUS_VECTOR   = 8'h18;
   localparam logic [7:0] SOFT_EOI_BIT      = 8'h08;
   localparam logic [7:0] VECTOR_BASE_MASK  = 8'hf0;
   localparam logic [7:0] TIMER_RESTART_BIT = 8'h10;
   localparam logic [7:0] VECTOR_RESET      = 8'h40;
   localparam logic [3:0] TIMER_A_CHANNEL   = 4'd13;
   localparam logic [7:0] LOW_NIBBLE        = 8'h0f;

   typedef struct packed {
      logic [2:0] kind;
      logic [4:0] offset;
      logic [7:0] write_data;
      logic [2:0] pin_index;
      logic       pin_level;
      logic [7:0] tick_count;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] vector;
      logic       irq_line;
      logic       irq_changed;
   } rsp_type;

   // Prescale divisor for a three-bit timer mode.
   function automatic logic [7:0] prescale_of(input logic [2:0] mode);
      logic [7:0] r;
      unique case (mode)
         3'd0: r = 8'd0;
         3'd1: r = 8'd4;
         3'd2: r = 8'd10;
         3'd3: r = 8'd16;
         3'd4: r = 8'd50;
         3'd5: r = 8'd64;
         3'd6: r = 8'd100;
         default: r = 8'd200;
      endcase
      return r;
   endfunction

   // Interrupt channel of a GPIO line.
   function automatic logic [3:0] pin_channel(input logic [2:0] pin);
      logic [3:0] r;
      unique case (pin)
         3'd0: r = 4'd0;
         3'd1: r = 4'd1;
         3'd2: r = 4'd2;
         3'd3: r = 4'd3;
         3'd4: r = 4'd6;
         3'd5: r = 4'd7;
         3'd6: r = 4'd14;
         default: r = 4'd15;
      endcase
      return r;
   endfunction

   // Interrupt channel of a timer.
   function automatic logic [3:0] timer_channel(input logic [1:0] t);
      logic [3:0] r;
      unique case (t)
         2'd0: r = TIMER_A_CHANNEL;
         2'd1: r = 4'd8;
         2'd2: r = 4'd5;
         default: r = 4'd4;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/mfp_timer_unit.sv
`default_nettype none
// Shared prescale unit: one subtract-and-compare step of the prescaler per cycle.
// Given the accumulator, divisor, count and reload of one timer, it produces the
// values after one prescaler step and whether that step expired the timer.
module mfp_timer_unit
   import mfp_pkg::*;
(
   input  wire  logic [8:0] acc,
   input  wire  logic [7:0] scale,
   input  wire  logic [7:0] count,
   input  wire  logic [7:0] reload,
   output logic             step,
   output logic [8:0] acc_next,
   output logic [7:0] count_next,
   output logic             expire
);
   logic [7:0] base;
   logic [7:0] dec;

   always_comb begin
      step = (acc >= {1'b0, scale});
      acc_next = acc - {1'b0, scale};
      base = (count == 8'd0) ? reload : count;
      dec = base - 8'd1;
      expire = (dec == 8'd0);
      count_next = expire ? reload : dec;
   end
endmodule
`default_nettype wire

>>> rtl/multi_function_peripheral_intc_timers.sv
`default_nettype none
// Multi-function peripheral with eight GPIO lines, a sixteen-channel prioritized
// interrupt controller and four 8-bit prescaled timers. One request beat is a
// register read or write, a pin change, a tick of timer clocks or an interrupt
// acknowledge, and each gives exactly one response beat. Reads, writes and pin
// changes pass from accept through the execute state to the response state. An
// acknowledge scans the sixteen channels one per cycle from the highest. A tick
// runs the four timers in turn through one shared prescale unit that performs one
// prescaler step per cycle. A stopped timer is skipped at its load step; a running
// one is loaded, stepped until its accumulator falls below the divisor, and then
// closed. The block takes no new request until the response beat of the current
// one is taken.
module multi_function_peripheral_intc_timers
   import mfp_pkg::*;
#(
   parameter int TICK_BITS = 8
)
(
   input  wire  logic    clock,
   input  wire  logic    reset,
   input  wire  logic    req_valid,
   output logic          req_ready,
   input  wire  req_type req_data,
   output logic          rsp_valid,
   input  wire  logic    rsp_ready,
   output rsp_type       rsp_data
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_TICK = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_RESP = 3'd4;

   localparam int TB = (TICK_BITS < 8) ? TICK_BITS : 8;
   localparam logic [7:0] TICK_MASK = 8'((9'd1 << TB) - 9'd1);

   logic [2:0]  state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;
   logic        before_ff, before_in;

   logic [7:0]  gpio_ff, gpio_in;
   logic [7:0]  edge_ff, edge_in;
   logic [7:0]  ddr_ff, ddr_in;
   logic [15:0] ier_ff, ier_in;
   logic [15:0] ipr_ff, ipr_in;
   logic [15:0] isr_ff, isr_in;
   logic [15:0] imr_ff, imr_in;
   logic [7:0]  vr_ff, vr_in;
   logic [7:0]  ctl_ff [3];
   logic [7:0]  ctl_in [3];
   logic [3:0]  mode_ff [4];
   logic [3:0]  mode_in [4];
   logic [7:0]  reload_ff [4];
   logic [7:0]  reload_in [4];
   logic [7:0]  count_ff [4];
   logic [7:0]  count_in [4];
   logic [7:0]  pacc_ff [4];
   logic [7:0]  pacc_in [4];
   logic        irq_ff, irq_in;

   logic [1:0]  tsel_ff, tsel_in;
   logic [8:0]  acc_ff, acc_in;
   logic        tload_ff, tload_in;
   logic [3:0]  ch_ff, ch_in;

   logic [7:0]  u_scale;
   logic        u_step, u_expire;
   logic [8:0]  u_acc_next;
   logic [7:0]  u_count_next;

   assign u_scale = prescale_of(mode_ff[tsel_ff][2:0]);

   mfp_timer_unit u_timer (
      .acc        (acc_ff),
      .scale      (u_scale),
      .count      (count_ff[tsel_ff]),
      .reload     (reload_ff[tsel_ff]),
      .step       (u_step),
      .acc_next   (u_acc_next),
      .count_next (u_count_next),
      .expire     (u_expire)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;

   // Sequencer and state update.
   always_comb begin
      logic [7:0]  m;
      logic [7:0]  lvl;
      logic [15:0] bit16;
      logic [15:0] live;
      logic [1:0]  t;
      logic [7:0]  rd;
      logic [7:0]  tk;
      state_in  = state_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      before_in = before_ff;
      gpio_in   = gpio_ff;
      edge_in   = edge_ff;
      ddr_in    = ddr_ff;
      ier_in    = ier_ff;
      ipr_in    = ipr_ff;
      isr_in    = isr_ff;
      imr_in    = imr_ff;
      vr_in     = vr_ff;
      ctl_in    = ctl_ff;
      mode_in   = mode_ff;
      reload_in = reload_ff;
      count_in  = count_ff;
      pacc_in   = pacc_ff;
      irq_in    = irq_ff;
      tsel_in   = tsel_ff;
      acc_in    = acc_ff;
      tload_in  = tload_ff;
      ch_in     = ch_ff;
      m = 8'd1 << req_ff.pin_index;
      lvl = 8'd0;
      bit16 = 16'd1 << ch_ff;
      live = ipr_ff & ier_ff & imr_ff;
      t = 2'd0;
      rd = 8'd0;
      tk = req_ff.tick_count & TICK_MASK;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               before_in = irq_ff;
               rsp_in    = '0;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
            unique case (req_ff.kind)
               KIND_READ: begin
                  unique case (req_ff.offset)
                     REG_GPIO:  rd = gpio_ff;
                     REG_EDGE:  rd = edge_ff;
                     REG_DDR:   rd = ddr_ff;
                     REG_IERA:  rd = ier_ff[15:8];
                     REG_IERB:  rd = ier_ff[7:0];
                     REG_IPRA:  rd = ipr_ff[15:8];
                     REG_IPRB:  rd = ipr_ff[7:0];
                     REG_ISRA:  rd = isr_ff[15:8];
                     REG_ISRB:  rd = isr_ff[7:0];
                     REG_IMRA:  rd = imr_ff[15:8];
                     REG_IMRB:  rd = imr_ff[7:0];
                     REG_VR:    rd = vr_ff;
                     REG_TACR:  rd = ctl_ff[0];
                     REG_TBCR:  rd = ctl_ff[1];
                     REG_TCDCR: rd = ctl_ff[2];
                     REG_TADR:  rd = count_ff[0];
                     REG_TBDR:  rd = count_ff[1];
                     REG_TCDR:  rd = count_ff[2];
                     REG_TDDR:  rd = count_ff[3];
                     default:   rd = 8'd0;
                  endcase
                  rsp_in.read_data = rd;
               end
               KIND_WRITE: begin
                  unique case (req_ff.offset)
                     REG_GPIO: gpio_in = (gpio_ff & ~ddr_ff) | (req_ff.write_data & ddr_ff);
                     REG_EDGE: edge_in = req_ff.write_data;
                     REG_DDR:  ddr_in = req_ff.write_data;
                     REG_IERA: begin
                        ier_in = {req_ff.write_data, ier_ff[7:0]};
                        ipr_in = ipr_ff & ier_in;
                     end
                     REG_IERB: begin
                        ier_in = {ier_ff[15:8], req_ff.write_data};
                        ipr_in = ipr_ff & ier_in;
                     end
                     REG_IPRA: ipr_in = ipr_ff & {req_ff.write_data, 8'hff};
                     REG_IPRB: ipr_in = ipr_ff & {8'hff, req_ff.write_data};
                     REG_ISRA: isr_in = isr_ff & {req_ff.write_data, 8'hff};
                     REG_ISRB: isr_in = isr_ff & {8'hff, req_ff.write_data};
                     REG_IMRA: imr_in = {req_ff.write_data, imr_ff[7:0]};
                     REG_IMRB: imr_in = {imr_ff[15:8], req_ff.write_data};
                     REG_VR:   vr_in = req_ff.write_data;
                     REG_TACR, REG_TBCR: begin
                        t = (req_ff.offset == REG_TACR) ? 2'd0 : 2'd1;
                        ctl_in[t] = req_ff.write_data;
                        mode_in[t] = req_ff.write_data[3:0];
                        if ((req_ff.write_data & TIMER_RESTART_BIT) != 8'd0) begin
                           count_in[t] = reload_ff[t];
                        end
                     end
                     REG_TCDCR: begin
                        ctl_in[2] = req_ff.write_data;
                        mode_in[2] = {1'b0, req_ff.write_data[6:4]};
                        mode_in[3] = {1'b0, req_ff.write_data[2:0]};
                     end
                     REG_TADR, REG_TBDR, REG_TCDR, REG_TDDR: begin
                        t = 2'(req_ff.offset - REG_TADR);
                        reload_in[t] = req_ff.write_data;
                        if (count_ff[t] == 8'd0) begin
                           count_in[t] = req_ff.write_data;
                        end
                     end
                     default: ;
                  endcase
                  irq_in = ((ipr_in & ier_in & imr_in) != 16'd0);
               end
               KIND_PIN: begin
                  lvl = req_ff.pin_level ? (gpio_ff | m) : (gpio_ff & ~m);
                  gpio_in = lvl;
                  if (((gpio_ff ^ lvl) & m) != 8'd0
                      && (((edge_ff & m) != 8'd0) == ((lvl & m) != 8'd0))) begin
                     ipr_in = ipr_ff
                              | (ier_ff & (16'd1 << pin_channel(req_ff.pin_index)));
                  end
                  irq_in = ((ipr_in & ier_ff & imr_ff) != 16'd0);
               end
               KIND_TICK: begin
                  if (tk != 8'd0) begin
                     tsel_in  = 2'd0;
                     tload_in = 1'b1;
                     state_in = ST_TICK;
                  end else begin
                     irq_in = (live != 16'd0);
                  end
               end
               KIND_ACK: begin
                  ch_in    = 4'd15;
                  state_in = ST_SCAN;
               end
               default: ;
            endcase
         end
         ST_TICK: begin
            if (tload_ff) begin
               // Load the selected timer, or skip it when stopped.
               if (u_scale == 8'd0 || reload_ff[tsel_ff] == 8'd0) begin
                  if (tsel_ff == 2'd3) begin
                     irq_in   = (live != 16'd0);
                     state_in = ST_RESP;
                  end else begin
                     tsel_in = tsel_ff + 2'd1;
                  end
               end else begin
                  acc_in   = {1'b0, pacc_ff[tsel_ff]} + {1'b0, tk};
                  tload_in = 1'b0;
               end
            end else if (u_step) begin
               acc_in = u_acc_next;
               count_in[tsel_ff] = u_count_next;
               if (u_expire) begin
                  ipr_in = ipr_ff | (ier_ff & (16'd1 << timer_channel(tsel_ff)));
               end
            end else begin
               pacc_in[tsel_ff] = acc_ff[7:0];
               tload_in = 1'b1;
               if (tsel_ff == 2'd3) begin
                  irq_in   = (live != 16'd0);
                  state_in = ST_RESP;
               end else begin
                  tsel_in = tsel_ff + 2'd1;
               end
            end
         end
         ST_SCAN: begin
            // One channel per cycle, highest first.
            if ((live & bit16) != 16'd0) begin
               ipr_in = ipr_ff & ~bit16;
               if ((vr_ff & SOFT_EOI_BIT) != 8'd0) begin
                  isr_in = isr_ff | bit16;
               end
               irq_in = ((live & ~bit16) != 16'd0);
               rsp_in.vector = (vr_ff & VECTOR_BASE_MASK) | {4'd0, ch_ff};
               state_in = ST_RESP;
            end else if (ch_ff == 4'd0) begin
               rsp_in.vector = SPURIOUS_VECTOR;
               state_in = ST_RESP;
            end else begin
               ch_in = ch_ff - 4'd1;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (state_in == ST_RESP && state_ff != ST_RESP) begin
         rsp_in.irq_line = irq_in;
         rsp_in.irq_changed = (irq_in != before_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         gpio_ff   <= 8'hff;
         edge_ff   <= 8'd0;
         ddr_ff    <= 8'd0;
         ier_ff    <= 16'd0;
         ipr_ff    <= 16'd0;
         isr_ff    <= 16'd0;
         imr_ff    <= 16'd0;
         vr_ff     <= VECTOR_RESET;
         ctl_ff    <= '{default: 8'd0};
         mode_ff   <= '{default: 4'd0};
         reload_ff <= '{default: 8'd0};
         count_ff  <= '{default: 8'd0};
         pacc_ff   <= '{default: 8'd0};
         irq_ff    <= 1'b0;
         tsel_ff   <= 2'd0;
         tload_ff  <= 1'b1;
      end else begin
         state_ff  <= state_in;
         gpio_ff   <= gpio_in;
         edge_ff   <= edge_in;
         ddr_ff    <= ddr_in;
         ier_ff    <= ier_in;
         ipr_ff    <= ipr_in;
         isr_ff    <= isr_in;
         imr_ff    <= imr_in;
         vr_ff     <= vr_in;
         ctl_ff    <= ctl_in;
         mode_ff   <= mode_in;
         reload_ff <= reload_in;
         count_ff  <= count_in;
         pacc_ff   <= pacc_in;
         irq_ff    <= irq_in;
         tsel_ff   <= tsel_in;
         tload_ff  <= tload_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      before_ff <= before_in;
      acc_ff    <= acc_in;
      ch_ff     <= ch_in;
   end
endmodule
`default_nettype wire

>>> bench/multi_function_peripheral_intc_timers_tb.sv
`default_nettype none
module multi_function_peripheral_intc_timers_tb
   import mfp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   multi_function_peripheral_intc_timers i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Shadow of the peripheral's register state.
   logic [7:0]  sh_gpio, sh_edge, sh_ddr, sh_vr;
   logic [15:0] sh_ier, sh_ipr, sh_isr, sh_imr;
   logic [7:0]  sh_ctrl [3];
   logic [3:0]  sh_mode [4];
   logic [7:0]  sh_reload [4];
   logic [7:0]  sh_count [4];
   logic [7:0]  sh_accum [4];
   logic        sh_irq;

   rsp_type     expected_rsps [$];
   int          fail_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          recv_hold;
   int          cycle_count;

   // Each row of the directed table carries an optional typed-in answer.
   typedef struct {
      req_type req;
      bit      has_answer;
      rsp_type answer;
   } directed_row_type;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] divisor_of(input logic [2:0] m);
      logic [7:0] d;
      case (m)
         3'd0: d = 8'd0;
         3'd1: d = 8'd4;
         3'd2: d = 8'd10;
         3'd3: d = 8'd16;
         3'd4: d = 8'd50;
         3'd5: d = 8'd64;
         3'd6: d = 8'd100;
         default: d = 8'd200;
      endcase
      return d;
   endfunction

   function automatic logic [3:0] line_channel(input logic [2:0] p);
      logic [3:0] c;
      case (p)
         3'd4: c = 4'd6;
         3'd5: c = 4'd7;
         3'd6: c = 4'd14;
         3'd7: c = 4'd15;
         default: c = {1'b0, p};
      endcase
      return c;
   endfunction

   task automatic shadow_reset();
      sh_gpio = 8'hff; sh_edge = '0; sh_ddr = '0; sh_vr = VECTOR_RESET;
      sh_ier = '0; sh_ipr = '0; sh_isr = '0; sh_imr = '0; sh_irq = 1'b0;
      for (int i = 0; i < 4; i++) begin
         sh_mode[i] = '0; sh_reload[i] = '0; sh_count[i] = '0; sh_accum[i] = '0;
         if (i < 3) sh_ctrl[i] = '0;
      end
   endtask

   function automatic void raise(input logic [3:0] ch);
      if (sh_ier[ch]) sh_ipr[ch] = 1'b1;
   endfunction

   function automatic void advance_timer(input int t, input int ticks);
      int d;
      int acc;
      d = divisor_of(sh_mode[t][2:0]);
      if (d == 0 || sh_reload[t] == 0) return;
      acc = sh_accum[t] + ticks;
      while (acc >= d) begin
         acc -= d;
         if (sh_count[t] == 0) sh_count[t] = sh_reload[t];
         sh_count[t] = sh_count[t] - 8'd1;
         if (sh_count[t] == 0) begin
            sh_count[t] = sh_reload[t];
            case (t)
               0: raise(TIMER_A_CHANNEL);
               1: raise(4'd8);
               2: raise(4'd5);
               default: raise(4'd4);
            endcase
         end
      end
      sh_accum[t] = acc[7:0];
   endfunction

   function automatic logic [7:0] reg_value(input logic [4:0] off);
      case (off)
         REG_GPIO:  return sh_gpio;
         REG_EDGE:  return sh_edge;
         REG_DDR:   return sh_ddr;
         REG_IERA:  return sh_ier[15:8];
         REG_IERB:  return sh_ier[7:0];
         REG_IPRA:  return sh_ipr[15:8];
         REG_IPRB:  return sh_ipr[7:0];
         REG_ISRA:  return sh_isr[15:8];
         REG_ISRB:  return sh_isr[7:0];
         REG_IMRA:  return sh_imr[15:8];
         REG_IMRB:  return sh_imr[7:0];
         REG_VR:    return sh_vr;
         REG_TACR:  return sh_ctrl[0];
         REG_TBCR:  return sh_ctrl[1];
         REG_TCDCR: return sh_ctrl[2];
         REG_TADR:  return sh_count[0];
         REG_TBDR:  return sh_count[1];
         REG_TCDR:  return sh_count[2];
         REG_TDDR:  return sh_count[3];
         default:   return 8'h00;
      endcase
   endfunction

   function automatic void store_reg(input logic [4:0] off, input logic [7:0] v);
      int t;
      case (off)
         REG_GPIO:  sh_gpio = (sh_gpio & ~sh_ddr) | (v & sh_ddr);
         REG_EDGE:  sh_edge = v;
         REG_DDR:   sh_ddr = v;
         REG_IERA:  begin sh_ier[15:8] = v; sh_ipr &= sh_ier; end
         REG_IERB:  begin sh_ier[7:0] = v; sh_ipr &= sh_ier; end
         REG_IPRA:  sh_ipr[15:8] &= v;
         REG_IPRB:  sh_ipr[7:0] &= v;
         REG_ISRA:  sh_isr[15:8] &= v;
         REG_ISRB:  sh_isr[7:0] &= v;
         REG_IMRA:  sh_imr[15:8] = v;
         REG_IMRB:  sh_imr[7:0] = v;
         REG_VR:    sh_vr = v;
         REG_TACR, REG_TBCR: begin
            t = (off == REG_TACR) ? 0 : 1;
            sh_ctrl[t] = v;
            sh_mode[t] = v[3:0];
            if ((v & TIMER_RESTART_BIT) != 0) sh_count[t] = sh_reload[t];
         end
         REG_TCDCR: begin
            sh_ctrl[2] = v;
            sh_mode[2] = {1'b0, v[6:4]};
            sh_mode[3] = {1'b0, v[2:0]};
         end
         REG_TADR, REG_TBDR, REG_TCDR, REG_TDDR: begin
            t = off - REG_TADR;
            sh_reload[t] = v;
            if (sh_count[t] == 0) sh_count[t] = v;
         end
         default: ;
      endcase
   endfunction

   // Predicts the response beat of one request and updates the shadow.
   function automatic rsp_type predict_response(input req_type r);
      rsp_type    p;
      logic       prior;
      logic [7:0] m;
      logic [7:0] old;
      logic [15:0] live;
      p = '0;
      prior = sh_irq;
      case (r.kind)
         KIND_READ: p.read_data = reg_value(r.offset);
         KIND_WRITE: begin
            store_reg(r.offset, r.write_data);
            sh_irq = |(sh_ipr & sh_ier & sh_imr);
         end
         KIND_PIN: begin
            m = 8'd1 << r.pin_index;
            old = sh_gpio;
            sh_gpio = r.pin_level ? (sh_gpio | m) : (sh_gpio & ~m);
            if (((old ^ sh_gpio) & m) != 0 && ((sh_edge & m) != 0) == r.pin_level)
               raise(line_channel(r.pin_index));
            sh_irq = |(sh_ipr & sh_ier & sh_imr);
         end
         KIND_TICK: begin
            if (r.tick_count != 0)
               for (int t = 0; t < 4; t++) advance_timer(t, r.tick_count);
            sh_irq = |(sh_ipr & sh_ier & sh_imr);
         end
         KIND_ACK: begin
            live = sh_ipr & sh_ier & sh_imr;
            p.vector = SPURIOUS_VECTOR;
            for (int ch = 15; ch >= 0; ch--) begin
               if (live[ch]) begin
                  sh_ipr[ch] = 1'b0;
                  if ((sh_vr & SOFT_EOI_BIT) != 0) sh_isr[ch] = 1'b1;
                  sh_irq = |(sh_ipr & sh_ier & sh_imr);
                  p.vector = (sh_vr & VECTOR_BASE_MASK) | ch[7:0];
                  break;
               end
            end
         end
         default: ;
      endcase
      p.irq_line = sh_irq;
      p.irq_changed = (sh_irq != prior);
      return p;
   endfunction

   // Sends one beat after a random idle gap and waits for its acceptance.
   // Valid drops only in idle cycles, so a following beat may go out at once.
   task automatic send_beat(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_checked(input req_type r);
      expected_rsps.push_back(predict_response(r));
      send_beat(r);
   endtask

   function automatic req_type make_req(input logic [2:0] k, input logic [4:0] off,
                                        input logic [7:0] d);
      req_type r;
      r = '0;
      r.kind = k; r.offset = off; r.write_data = d;
      r.pin_index = d[2:0]; r.pin_level = d[3]; r.tick_count = d;
      return r;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int      pick;
      r = req_type'($urandom);
      pick = $urandom_range(99);
      if (pick < 10) r.kind = KIND_READ;
      else if (pick < 38) r.kind = KIND_WRITE;
      else if (pick < 58) r.kind = KIND_PIN;
      else if (pick < 76) r.kind = KIND_TICK;
      else if (pick < 96) r.kind = KIND_ACK;
      else r.kind = 3'($urandom_range(5, 7));
      if (r.kind == KIND_WRITE && $urandom_range(3) != 0)
         r.offset = 5'($urandom_range(REG_TDDR));
      // Keep ticks mostly short so slow divisors are still reached.
      if (r.kind == KIND_TICK && $urandom_range(3) != 0)
         r.tick_count = 8'($urandom_range(1, 40));
      return r;
   endfunction

   // Response side: random stall, long hold-off on demand, and checking.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response beat with nothing expected: %p", rsp_data);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.read_data !== want.read_data) begin
                  $error("read_data expected %h actual %h", want.read_data,
                         rsp_data.read_data);
                  fail_count++;
               end
               if (rsp_data.vector !== want.vector) begin
                  $error("vector expected %h actual %h", want.vector, rsp_data.vector);
                  fail_count++;
               end
               if (rsp_data.irq_line !== want.irq_line) begin
                  $error("irq_line expected %b actual %b", want.irq_line,
                         rsp_data.irq_line);
                  fail_count++;
               end
               if (rsp_data.irq_changed !== want.irq_changed) begin
                  $error("irq_changed expected %b actual %b", want.irq_changed,
                         rsp_data.irq_changed);
                  fail_count++;
               end
            end
         end
         rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Long receiver hold-off, counted here, while requests keep coming.
   initial begin
      recv_hold = 1'b0;
      wait (send_idle_pct == 13);
      repeat (200) @(posedge clock);
      recv_hold = 1'b1;
      repeat (400) @(posedge clock);
      recv_hold = 1'b0;
   end

   // Generous watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      directed_row_type rows [$];
      directed_row_type row;
      int               n;
      fail_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      req_valid = 1'b0;
      req_data = '0;
      reset = 1'b1;
      shadow_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part: reset values, extremes, each kind and odd cases.
      rows.push_back('{make_req(KIND_READ, REG_GPIO, 8'h00), 1, '{8'hff, 8'h00, 0, 0}});
      rows.push_back('{make_req(KIND_READ, REG_VR, 8'h00), 1, '{8'h40, 8'h00, 0, 0}});
      rows.push_back('{make_req(KIND_READ, 5'h1f, 8'h00), 1, '{8'h00, 8'h00, 0, 0}});
      rows.push_back('{make_req(KIND_ACK, 5'h00, 8'h00), 1,
                       '{8'h00, SPURIOUS_VECTOR, 0, 0}});
      rows.push_back('{make_req(KIND_WRITE, 5'h1f, 8'hff), 0, '0});
      rows.push_back('{make_req(KIND_WRITE, REG_GPIO, 8'h00), 0, '0});
      rows.push_back('{make_req(KIND_WRITE, REG_DDR, 8'h0f), 0, '0});
      rows.push_back('{make_req(KIND_WRITE, REG_GPIO, 8'h00), 0, '0});
      rows.push_back('{make_req(KIND_WRITE, REG_IERA, 8'hff), 0, '0});
      rows.push_back('{make_req(KIND_WRITE, REG_IERB, 8'hff), 0, '0});
      rows.push_back('{make_req(KIND_WRITE, REG_IMRA, 8'hff), 0, '0});
      rows.push_back('{make_req(KIND_WRITE, REG_IMRB, 8'hff), 0, '0});
      rows.push_back('{make_req(KIND_WRITE, REG_VR, 8'hf8), 0, '0});
      rows.push_back('{make_req(KIND_PIN, 5'h00, 8'h07), 0, '0});
      rows.push_back('{make_req(KIND_PIN, 5'h00, 8'h00), 0, '0});
      rows.push_back('{make_req(KIND_WRITE, REG_TADR, 8'h02), 0, '0});
      rows.push_back('{make_req(KIND_WRITE, REG_TACR, 8'h19), 0, '0});
      rows.push_back('{make_req(KIND_TICK, 5'h00, 8'h00), 0, '0});
      rows.push_back('{make_req(KIND_TICK, 5'h00, 8'hff), 0, '0});
      rows.push_back('{make_req(KIND_WRITE, REG_TCDCR, 8'hff), 0, '0});
      rows.push_back('{make_req(KIND_ACK, 5'h00, 8'h00), 0, '0});
      rows.push_back('{make_req(KIND_ACK, 5'h00, 8'h00), 0, '0});
      rows.push_back('{make_req(KIND_WRITE, REG_ISRA, 8'h00), 0, '0});
      rows.push_back('{make_req(3'd7, 5'h00, 8'h00), 0, '0});
      rows.push_back('{make_req(KIND_WRITE, REG_IERA, 8'h00), 0, '0});
      foreach (rows[i]) begin
         row = rows[i];
         if (row.has_answer) begin
            void'(predict_response(row.req));
            expected_rsps.push_back(row.answer);
            send_beat(row.req);
         end else begin
            send_checked(row.req);
         end
      end

      // Random part in three idling phases.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 52 : 0;
         recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 13 : 0;
         n = (phase == 2) ? 250 : 350;
         for (int i = 0; i < n; i++) begin
            send_checked(random_req());
            // Sender pause until the block has drained.
            if (phase == 1 && i == 100) begin
               req_valid <= 1'b0;
               while (expected_rsps.size() != 0) @(posedge clock);
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> multi_function_peripheral_intc_timers.f
rtl/mfp_pkg.sv
rtl/mfp_timer_unit.sv
rtl/multi_function_peripheral_intc_timers.sv
bench/multi_function_peripheral_intc_timers_tb.sv
